>>> rtl/sample_framer_with_command_parser_unit_assert.svh
// Assertion macros for the framer block.
`ifndef SAMPLE_FRAMER_WITH_COMMAND_PARSER_UNIT_ASSERT_SVH
`define SAMPLE_FRAMER_WITH_COMMAND_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SFCP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sfcp assertion failed");
`define SFCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfcp implication failed");
`else
`define SFCP_ASSERT(lbl, clk, rst_n, prop)
`define SFCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/sfcp_pkg.sv
package sfcp_pkg;

  localparam int unsigned CMD_DEPTH   = 5;
  localparam int unsigned FRAME_BYTES = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;

  localparam logic [7:0] CHAR_I = 8'h49;
  localparam logic [7:0] CHAR_N = 8'h4E;
  localparam logic [7:0] CHAR_P = 8'h50;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_R = 8'h52;

  typedef enum logic {
    KIND_CMD  = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef struct packed {
    logic [9:0] sample_a;
    logic [9:0] sample_b;
  } frame_t;

  // data bytes of a frame, in send order
  function automatic logic [7:0] data_byte(frame_t f, logic [1:0] sel);
    logic [7:0] b;
    unique case (sel)
      2'd0:    b = {6'b0, f.sample_a[9:8]};
      2'd1:    b = f.sample_a[7:0];
      2'd2:    b = {6'b0, f.sample_b[9:8]};
      default: b = f.sample_b[7:0];
    endcase
    return b;
  endfunction

endpackage

>>> rtl/sfcp_front.sv
module sfcp_front #(
  parameter int unsigned CMD_DEPTH = sfcp_pkg::CMD_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic              kind_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [9:0]        sample_a_i,
  input  logic [9:0]        sample_b_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output sfcp_pkg::frame_t  q_word_o
);

  localparam int unsigned IW = $clog2(CMD_DEPTH);

  logic [7:0]    store_q [CMD_DEPTH];
  logic [IW-1:0] idx_q, idx_d;
  logic          send_q, send_d;
  logic          accept;
  logic          is_cmd;
  logic          is_flag;

  assign full_o   = q_full_i;
  assign accept   = push_i && !q_full_i;
  assign is_cmd   = (kind_i == sfcp_pkg::KIND_CMD);
  assign is_flag  = (rx_byte_i == sfcp_pkg::FLAG_BYTE);
  assign q_push_o = accept && !is_cmd && send_q;
  assign q_word_o = '{sample_a: sample_a_i, sample_b: sample_b_i};

  always_comb begin
    idx_d  = idx_q;
    send_d = send_q;
    if (accept && is_cmd) begin
      if (is_flag) begin
        idx_d = '0;
        if (store_q[0] == sfcp_pkg::CHAR_I && store_q[1] == sfcp_pkg::CHAR_N &&
            store_q[2] == sfcp_pkg::CHAR_I) begin
          send_d = 1'b1;
        end
        if (store_q[0] == sfcp_pkg::CHAR_P && store_q[1] == sfcp_pkg::CHAR_A &&
            store_q[2] == sfcp_pkg::CHAR_R) begin
          send_d = 1'b0;
        end
      end else if (idx_q == IW'(CMD_DEPTH - 1)) begin
        idx_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      send_q <= 1'b0;
      for (int i = 0; i < CMD_DEPTH; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      idx_q  <= idx_d;
      send_q <= send_d;
      if (accept && is_cmd && !is_flag) begin
        store_q[idx_q] <= rx_byte_i;
      end
    end
  end

endmodule

>>> rtl/sfcp_queue.sv
`include "sample_framer_with_command_parser_unit_assert.svh"

module sfcp_queue #(
  parameter int unsigned DEPTH = sfcp_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfcp_pkg::frame_t word_i,
  output logic             full_o,
  input  logic             pop_i,
  output sfcp_pkg::frame_t word_o,
  output logic             empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sfcp_pkg::frame_t mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign word_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= word_i;
    end
  end

  `SFCP_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CW'(DEPTH))
  `SFCP_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i, !full_o)
  `SFCP_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o)

endmodule

>>> rtl/sfcp_back.sv
`include "sample_framer_with_command_parser_unit_assert.svh"

module sfcp_back #(
  parameter int unsigned FRAME_BYTES = sfcp_pkg::FRAME_BYTES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  sfcp_pkg::frame_t q_word_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [7:0]       out_byte_o,
  output logic             last_o
);

  localparam int unsigned NB = (FRAME_BYTES > 4) ? 4 : FRAME_BYTES;
  localparam int unsigned PW = $clog2(NB + 1);

  sfcp_pkg::frame_t frame_q, frame_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic             busy_q, busy_d;
  logic             esc_q, esc_d;
  logic             valid_q, valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             adv;
  logic [7:0]       cur;

  assign adv        = !valid_q || pop_i;
  assign cur        = sfcp_pkg::data_byte(frame_q, pos_q[1:0]);
  assign empty_o    = !valid_q;
  assign out_byte_o = byte_q;
  assign last_o     = last_q;

  always_comb begin
    frame_d = frame_q;
    pos_d   = pos_q;
    busy_d  = busy_q;
    esc_d   = esc_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    q_pop_o = 1'b0;
    if (!busy_q) begin
      if (!q_empty_i) begin
        q_pop_o = 1'b1;
        frame_d = q_word_i;
        busy_d  = 1'b1;
        pos_d   = '0;
        esc_d   = 1'b0;
      end
      if (adv) begin
        valid_d = 1'b0;
      end
    end else if (adv) begin
      valid_d = 1'b1;
      last_d  = 1'b0;
      if (pos_q == PW'(NB)) begin
        byte_d = sfcp_pkg::FLAG_BYTE;
        last_d = 1'b1;
        pos_d  = '0;
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          frame_d = q_word_i;
        end else begin
          busy_d = 1'b0;
        end
      end else if (esc_q) begin
        byte_d = (cur == sfcp_pkg::FLAG_BYTE) ? sfcp_pkg::ESC_FLAG : sfcp_pkg::ESC_ESC;
        esc_d  = 1'b0;
        pos_d  = pos_q + 1'b1;
      end else if (cur == sfcp_pkg::FLAG_BYTE || cur == sfcp_pkg::ESC_BYTE) begin
        byte_d = sfcp_pkg::ESC_BYTE;
        esc_d  = 1'b1;
      end else begin
        byte_d = cur;
        pos_d  = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      esc_q   <= 1'b0;
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      esc_q   <= esc_d;
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    byte_q  <= byte_d;
    last_q  <= last_d;
  end

  `SFCP_ASSERT_IMP(a_last_is_flag, clk_i, rst_ni, valid_q && last_q,
                   byte_q == sfcp_pkg::FLAG_BYTE)
  `SFCP_ASSERT_IMP(a_esc_in_frame, clk_i, rst_ni, esc_q, busy_q && pos_q < PW'(NB))
  `SFCP_ASSERT(a_pos_range, clk_i, rst_ni, pos_q <= PW'(NB))

endmodule

>>> rtl/sample_framer_with_command_parser_unit.sv
// Command parser and sample framer. A command word (kind 0) gives no output; a flag
// byte checks the first three stored bytes for INI (sending on) or PAR (sending off). A
// sample tick (kind 1) with sending on is queued as a frame, and the serialiser sends its
// stuffed data bytes and a closing flag marked last, one byte per cycle while pop is held,
// through its output register: up to 2*min(FRAME_BYTES,4)+1 bytes a frame, nine at most.
// Frames follow each other without a gap; a frame reaching an idle serialiser is first
// loaded into its frame register. Input words are taken every cycle until the two-entry
// frame queue is full, and full stays high while it is.
module sample_framer_with_command_parser_unit #(
  parameter int unsigned CMD_DEPTH   = sfcp_pkg::CMD_DEPTH,
  parameter int unsigned FRAME_BYTES = sfcp_pkg::FRAME_BYTES,
  parameter int unsigned QUEUE_DEPTH = sfcp_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       kind_i,
  input  logic [7:0] rx_byte_i,
  input  logic [9:0] sample_a_i,
  input  logic [9:0] sample_b_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  sfcp_pkg::frame_t push_word, head_word;
  logic             q_push, q_full, q_pop, q_empty;

  sfcp_front #(
    .CMD_DEPTH (CMD_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .kind_i     (kind_i),
    .rx_byte_i  (rx_byte_i),
    .sample_a_i (sample_a_i),
    .sample_b_i (sample_b_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_word_o   (push_word)
  );

  sfcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .word_i  (push_word),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .word_o  (head_word),
    .empty_o (q_empty)
  );

  sfcp_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_word_i   (head_word),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic [7:0] octet;
    logic       fin;
  } tx_byte_t;

  // directed row: n typed bytes, first byte in the top of exp, last one is the flag
  typedef struct {
    sfcp_pkg::kind_e kind;
    logic [7:0]      rx;
    logic [9:0]      a;
    logic [9:0]      b;
    bit              typed;
    int              n;
    logic [55:0]     exp;
  } row_t;

  localparam int HOLD_CYCLES = 80;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic       kind_i = 1'b0;
  logic [7:0] rx_byte_i = 8'h00;
  logic [9:0] sample_a_i = 10'h000;
  logic [9:0] sample_b_i = 10'h000;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_o;

  sample_framer_with_command_parser_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .kind_i     (kind_i),
    .rx_byte_i  (rx_byte_i),
    .sample_a_i (sample_a_i),
    .sample_b_i (sample_b_i),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

  // framer state as the block should hold it
  logic [7:0] cmd_mem [sfcp_pkg::CMD_DEPTH] = '{default: 8'h00};
  int         cmd_pos = 0;
  bit         tx_on = 1'b0;

  tx_byte_t   frame_scratch[$];
  tx_byte_t   bytes_due[$];

  int  words_sent = 0;
  int  bytes_checked = 0;
  int  frames_seen = 0;
  int  escapes_due = 0;
  int  full_stalls = 0;
  int  held_cycles = 0;
  int  fails = 0;
  int  burst_left = 0;
  bit  rx_hold_req = 1'b0;

  row_t dir_tbl [25] = '{
    '{sfcp_pkg::KIND_TICK, 8'h00, 10'h000, 10'h000, 1'b1, 0, 56'h0},
    '{sfcp_pkg::KIND_CMD, sfcp_pkg::CHAR_I, 10'h3FF, 10'h3FF, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_CMD, sfcp_pkg::CHAR_N, 10'h000, 10'h000, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_CMD, sfcp_pkg::CHAR_I, 10'h000, 10'h000, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_CMD, sfcp_pkg::FLAG_BYTE, 10'h000, 10'h000, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_TICK, 8'hFF, 10'h000, 10'h000, 1'b1, 5, 56'h00_00_00_00_7E_00_00},
    '{sfcp_pkg::KIND_TICK, 8'h00, 10'h3FF, 10'h3FF, 1'b1, 5, 56'h03_FF_03_FF_7E_00_00},
    '{sfcp_pkg::KIND_TICK, 8'h00, 10'h07E, 10'h07D, 1'b1, 7, 56'h00_7D_5E_00_7D_5D_7E},
    '{sfcp_pkg::KIND_TICK, 8'h00, 10'h27E, 10'h17D, 1'b1, 7, 56'h02_7D_5E_01_7D_5D_7E},
    '{sfcp_pkg::KIND_CMD, sfcp_pkg::CHAR_P, 10'h000, 10'h000, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_CMD, sfcp_pkg::CHAR_A, 10'h000, 10'h000, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_CMD, sfcp_pkg::CHAR_R, 10'h000, 10'h000, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_CMD, sfcp_pkg::FLAG_BYTE, 10'h000, 10'h000, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_TICK, 8'h00, 10'h155, 10'h2AA, 1'b1, 0, 56'h0},
    '{sfcp_pkg::KIND_CMD, sfcp_pkg::CHAR_I, 10'h000, 10'h000, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_CMD, sfcp_pkg::FLAG_BYTE, 10'h000, 10'h000, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_TICK, 8'h00, 10'h2AA, 10'h155, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_CMD, sfcp_pkg::CHAR_I, 10'h000, 10'h000, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_CMD, sfcp_pkg::CHAR_N, 10'h000, 10'h000, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_CMD, sfcp_pkg::CHAR_I, 10'h000, 10'h000, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_CMD, 8'hFF, 10'h000, 10'h000, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_CMD, 8'h00, 10'h000, 10'h000, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_CMD, sfcp_pkg::CHAR_P, 10'h000, 10'h000, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_CMD, sfcp_pkg::FLAG_BYTE, 10'h000, 10'h000, 1'b0, 0, 56'h0},
    '{sfcp_pkg::KIND_TICK, 8'h00, 10'h3FF, 10'h000, 1'b0, 0, 56'h0}
  };

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // works out the stuffed frame bytes a word gives and updates the command state
  task automatic frame_word(sfcp_pkg::kind_e k, logic [7:0] rx, logic [9:0] a,
                            logic [9:0] b);
    logic [7:0] data [4];
    int nb;
    frame_scratch.delete();
    if (k == sfcp_pkg::KIND_CMD) begin
      if (rx == sfcp_pkg::FLAG_BYTE) begin
        cmd_pos = 0;
        if (cmd_mem[0] == sfcp_pkg::CHAR_I && cmd_mem[1] == sfcp_pkg::CHAR_N &&
            cmd_mem[2] == sfcp_pkg::CHAR_I)
          tx_on = 1'b1;
        if (cmd_mem[0] == sfcp_pkg::CHAR_P && cmd_mem[1] == sfcp_pkg::CHAR_A &&
            cmd_mem[2] == sfcp_pkg::CHAR_R)
          tx_on = 1'b0;
      end else begin
        cmd_mem[cmd_pos] = rx;
        cmd_pos++;
        if (cmd_pos >= int'(sfcp_pkg::CMD_DEPTH)) cmd_pos = 0;
      end
    end else if (tx_on) begin
      data[0] = {6'b0, a[9:8]};
      data[1] = a[7:0];
      data[2] = {6'b0, b[9:8]};
      data[3] = b[7:0];
      nb = (sfcp_pkg::FRAME_BYTES > 4) ? 4 : int'(sfcp_pkg::FRAME_BYTES);
      for (int i = 0; i < nb; i++) begin
        if (data[i] == sfcp_pkg::FLAG_BYTE) begin
          frame_scratch.push_back('{sfcp_pkg::ESC_BYTE, 1'b0});
          frame_scratch.push_back('{sfcp_pkg::ESC_FLAG, 1'b0});
          escapes_due++;
        end else if (data[i] == sfcp_pkg::ESC_BYTE) begin
          frame_scratch.push_back('{sfcp_pkg::ESC_BYTE, 1'b0});
          frame_scratch.push_back('{sfcp_pkg::ESC_ESC, 1'b0});
          escapes_due++;
        end else begin
          frame_scratch.push_back('{data[i], 1'b0});
        end
      end
      frame_scratch.push_back('{sfcp_pkg::FLAG_BYTE, 1'b1});
    end
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_word(sfcp_pkg::kind_e k, logic [7:0] rx, logic [9:0] a, logic [9:0] b,
                           bit typed = 1'b0, int n = 0, logic [55:0] exp = '0);
    push       <= 1'b1;
    kind_i     <= k;
    rx_byte_i  <= rx;
    sample_a_i <= a;
    sample_b_i <= b;
    do @(posedge clk_i); while (full);
    frame_word(k, rx, a, b);
    if (typed) begin
      for (int i = 0; i < n; i++)
        bytes_due.push_back('{exp[55 - 8 * i -: 8], i == n - 1});
    end else begin
      foreach (frame_scratch[i]) bytes_due.push_back(frame_scratch[i]);
    end
    words_sent++;
    pace();
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (bytes_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [9:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return {2'($urandom_range(0, 3)), sfcp_pkg::FLAG_BYTE};
      1:       return {2'($urandom_range(0, 3)), sfcp_pkg::ESC_BYTE};
      2:       return 10'h000;
      3:       return 10'h3FF;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == sfcp_pkg::FLAG_BYTE);
    return v;
  endfunction

  task automatic send_cmd(logic [7:0] c);
    send_word(sfcp_pkg::KIND_CMD, c, 10'($urandom_range(0, 1023)),
              10'($urandom_range(0, 1023)));
  endtask

  task automatic send_tick();
    send_word(sfcp_pkg::KIND_TICK, 8'($urandom_range(0, 255)), pick_sample(), pick_sample());
  endtask

  initial begin : sender
    int  sel;
    bit  pressed;
    pressed = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i])
      send_word(dir_tbl[i].kind, dir_tbl[i].rx, dir_tbl[i].a, dir_tbl[i].b,
                dir_tbl[i].typed, dir_tbl[i].n, dir_tbl[i].exp);
    drain();

    while (words_sent < 300) begin
      if (!pressed && words_sent >= 140) begin
        // hold the receiver off while ticks keep coming, so full must rise
        pressed = 1'b1;
        send_cmd(sfcp_pkg::FLAG_BYTE);
        send_cmd(sfcp_pkg::CHAR_I);
        send_cmd(sfcp_pkg::CHAR_N);
        send_cmd(sfcp_pkg::CHAR_I);
        send_cmd(sfcp_pkg::FLAG_BYTE);
        rx_hold_req = 1'b1;
        repeat (10) send_tick();
        drain();
      end
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        send_cmd(sfcp_pkg::CHAR_I);
        send_cmd(sfcp_pkg::CHAR_N);
        send_cmd(sfcp_pkg::CHAR_I);
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) send_cmd(pick_plain());
        send_cmd(sfcp_pkg::FLAG_BYTE);
        repeat ($urandom_range(1, 6)) send_tick();
      end else if (sel < 7) begin
        send_cmd(sfcp_pkg::CHAR_P);
        send_cmd(sfcp_pkg::CHAR_A);
        send_cmd(sfcp_pkg::CHAR_R);
        send_cmd(sfcp_pkg::FLAG_BYTE);
        repeat ($urandom_range(1, 2)) send_tick();
      end else if (sel < 9) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0)
            send_tick();
          else
            send_cmd(($urandom_range(0, 5) == 0) ? sfcp_pkg::FLAG_BYTE :
                     8'($urandom_range(0, 255)));
        end
      end else begin
        // short packet: only one or two bytes are stored before the flag
        if ($urandom_range(0, 1) == 0) send_cmd(sfcp_pkg::CHAR_P);
        else send_cmd(sfcp_pkg::CHAR_I);
        if ($urandom_range(0, 1) == 0) send_cmd(sfcp_pkg::CHAR_N);
        send_cmd(sfcp_pkg::FLAG_BYTE);
        send_tick();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("sent %0d words; checked %0d bytes in %0d frames, %0d escapes expected",
             words_sent, bytes_checked, frames_seen, escapes_due);
    $display("input held by full for %0d cycles, output held off for %0d cycles",
             full_stalls, held_cycles);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : receiver
    int mode;
    int left;
    int tick;
    mode = 0;
    left = 0;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) begin
          @(posedge clk_i);
          held_cycles++;
        end
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(10, 60);
        end
        left--;
        tick++;
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= ($urandom_range(0, 3) == 0);
          default: pop <= (tick % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    tx_byte_t want;
    if (rst_ni) begin
      if (push && full) full_stalls++;
      if (pop && !empty) begin
        if (bytes_due.size() == 0) begin
          $error("unexpected word: out_byte %h last %b", out_byte_o, last_o);
          fails++;
        end else begin
          want = bytes_due.pop_front();
          if (out_byte_o !== want.octet) begin
            $error("out_byte: expected %h, actual %h", want.octet, out_byte_o);
            fails++;
          end
          if (last_o !== want.fin) begin
            $error("last: expected %b, actual %b", want.fin, last_o);
            fails++;
          end
          bytes_checked++;
          if (want.fin) frames_seen++;
        end
      end
    end
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sfcp_pkg.sv
rtl/sfcp_front.sv
rtl/sfcp_queue.sv
rtl/sfcp_back.sv
rtl/sample_framer_with_command_parser_unit.sv
tb/tb.sv
